>>> hw/rtl/qpht_pkg.sv
// Shared widths, codes and controller/datapath interface types for the hash table.
package qpht_pkg;

   localparam int FUNC_W    = 1;
   localparam int KEY_W     = 31;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int SLOT_W    = 6;
   localparam int SIZE_W    = 7;
   localparam int DEF_SLOTS = 64;
   localparam int DCNT_W    = $clog2(KEY_W);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

   localparam logic [STAT_W-1:0] STAT_INSERTED  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FOUND     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic             occ;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic probe_init;
      logic mem_read;
      logic probe_next;
      logic finish;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic probe_done;
   } sts_type;

endpackage

>>> hw/rtl/qpht_ctrl.sv
// Sequencer for clearing, division, probing and result hand-off.
module qpht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  qpht_pkg::sts_type sts,
   output qpht_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.probe_init = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.probe_done) begin
               // hold the verdict until the output register is free
               if (out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_accept_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIV))
      else $error("accepted transfer did not start the divide");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not presented");

   a_read_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_CHECK))
      else $error("slot read not followed by its check");

endmodule

>>> hw/rtl/qpht_dp.sv
// Datapath: size register, restoring divider, probe sequence, slot store, result register.
module qpht_dp #(
   parameter int SLOTS = qpht_pkg::DEF_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qpht_pkg::cmd_type             cmd,
   output qpht_pkg::sts_type             sts,
   input  logic                          csr_wr,
   input  logic [qpht_pkg::SIZE_W-1:0]   csr_wdata,
   input  logic [qpht_pkg::FUNC_W-1:0]   req_func,
   input  logic [qpht_pkg::KEY_W-1:0]    req_key,
   input  logic [qpht_pkg::VAL_W-1:0]    req_value,
   output logic [qpht_pkg::STAT_W-1:0]   rsp_status,
   output logic [qpht_pkg::VAL_W-1:0]    rsp_found_value,
   output logic [qpht_pkg::SLOT_W-1:0]   rsp_slot
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW   = qpht_pkg::SIZE_W;
   localparam int KW   = qpht_pkg::KEY_W;

   logic [SW-1:0]                 size_ff, size_in;
   logic [IDXW-1:0]               clr_ff, clr_in;
   logic [qpht_pkg::FUNC_W-1:0]   func_ff;
   logic [KW-1:0]                 key_ff;
   logic [qpht_pkg::VAL_W-1:0]    val_ff;
   logic [SW-1:0]                 n_ff, n_in;
   logic [KW-1:0]                 dvd_ff, dvd_in;
   logic [SW-1:0]                 rem_ff, rem_in;
   logic [qpht_pkg::DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [SW-1:0]                 off_ff, off_in;
   logic [SW-1:0]                 step_ff, step_in;
   logic [SW-1:0]                 pcnt_ff, pcnt_in;
   qpht_pkg::entry_type           rd_ff;
   qpht_pkg::entry_type           store_ff [SLOTS];
   logic [qpht_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [qpht_pkg::VAL_W-1:0]    found_ff, found_in;
   logic [qpht_pkg::SLOT_W-1:0]   slot_ff, slot_in;

   logic [SW:0]         n8, trial, sum, idx8, osum, t1, t2;
   logic [IDXW-1:0]     idx, waddr;
   logic                is_search, match, at_limit, we;
   qpht_pkg::entry_type wdata;

   assign n8        = {1'b0, n_ff};
   assign is_search = (func_ff == qpht_pkg::FUNC_SEARCH);
   assign match     = (rd_ff.key == key_ff);
   assign at_limit  = (pcnt_ff == (n_ff - SW'(1)));

   // current probe slot: home plus squared offset, folded once
   assign sum  = {1'b0, rem_ff} + {1'b0, off_ff};
   assign idx8 = (sum >= n8) ? (sum - n8) : sum;
   assign idx  = IDXW'(idx8);

   assign sts.clear_last = (clr_ff == IDXW'(SLOTS - 1));
   assign sts.div_last   = (dcnt_ff == '0);
   assign sts.probe_done = !rd_ff.occ || (is_search && match) || at_limit;

   always_comb begin
      size_in = size_ff;
      if (csr_wr) begin
         size_in = csr_wdata;
      end
   end

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + IDXW'(1);
      end
   end

   // clamp the size in use to 1..SLOTS at capture
   always_comb begin
      n_in = n_ff;
      if (cmd.capture) begin
         if (size_ff == '0) begin
            n_in = SW'(1);
         end else if (32'(size_ff) > SLOTS) begin
            n_in = SW'(SLOTS);
         end else begin
            n_in = size_ff;
         end
      end
   end

   // restoring divider, one dividend bit per cycle, keeps the remainder only
   always_comb begin
      trial   = {rem_ff, dvd_ff[KW-1]};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.capture) begin
         dvd_in  = req_key;
         rem_in  = '0;
         dcnt_in = qpht_pkg::DCNT_W'(KW - 1);
      end else if (cmd.div_step) begin
         dvd_in  = {dvd_ff[KW-2:0], 1'b0};
         rem_in  = (trial >= n8) ? SW'(trial - n8) : SW'(trial);
         dcnt_in = dcnt_ff - qpht_pkg::DCNT_W'(1);
      end
   end

   // offset i*i mod n advances by the odd step 2i+1 mod n
   always_comb begin
      osum    = {1'b0, off_ff} + {1'b0, step_ff};
      t1      = {1'b0, step_ff} + (SW+1)'(2);
      t2      = (t1 >= n8) ? (t1 - n8) : t1;
      off_in  = off_ff;
      step_in = step_ff;
      pcnt_in = pcnt_ff;
      if (cmd.probe_init) begin
         off_in  = '0;
         step_in = (n_ff == SW'(1)) ? '0 : SW'(1);
         pcnt_in = '0;
      end else if (cmd.probe_next) begin
         off_in  = (osum >= n8) ? SW'(osum - n8) : SW'(osum);
         step_in = (t2 >= n8) ? SW'(t2 - n8) : SW'(t2);
         pcnt_in = pcnt_ff + SW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      found_in  = found_ff;
      slot_in   = slot_ff;
      if (cmd.finish) begin
         found_in = '0;
         slot_in  = '0;
         if (!rd_ff.occ) begin
            if (is_search) begin
               status_in = qpht_pkg::STAT_NOT_FOUND;
            end else begin
               status_in = qpht_pkg::STAT_INSERTED;
               slot_in   = qpht_pkg::SLOT_W'(idx);
            end
         end else if (is_search && match) begin
            status_in = qpht_pkg::STAT_FOUND;
            found_in  = rd_ff.value;
            slot_in   = qpht_pkg::SLOT_W'(idx);
         end else if (is_search) begin
            status_in = qpht_pkg::STAT_NOT_FOUND;
         end else begin
            status_in = qpht_pkg::STAT_FULL;
         end
      end
   end

   // single write port shared by the clearing pass and inserts
   always_comb begin
      we    = cmd.clear_step || (cmd.finish && !is_search && !rd_ff.occ);
      waddr = cmd.clear_step ? clr_ff : idx;
      wdata = '0;
      if (!cmd.clear_step) begin
         wdata.occ   = 1'b1;
         wdata.key   = key_ff;
         wdata.value = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_ff <= store_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= qpht_pkg::SIZE_RESET;
         clr_ff  <= '0;
      end else begin
         size_ff <= size_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         val_ff  <= req_value;
      end
      n_ff      <= n_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      dcnt_ff   <= dcnt_in;
      off_ff    <= off_in;
      step_ff   <= step_in;
      pcnt_ff   <= pcnt_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      slot_ff   <= slot_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;
   assign rsp_slot        = slot_ff;

endmodule

>>> hw/rtl/quadratic_probe_hash_table_top.sv
// Top level of the quadratic-probing hash table: controller plus datapath.
//
//  channel  direction  ports                                 payload
//  req      in         req_valid / req_ready                 req_func, req_key, req_value
//  rsp      out        rsp_valid / rsp_ready                 rsp_status, rsp_found_value, rsp_slot
//  csr      in         csr_valid / csr_ready                 csr_wdata (table size)
//
// An item is captured, the divider works out the home slot, then each probe reads a slot
// and then checks it, for p probes with p from 1 to the table size in use.
// After reset a clearing pass wipes the occupied bits of all SLOTS entries; req_ready stays
// low meanwhile, csr writes are taken at any time.
// A finished result waits in the output register; the next transfer is accepted
// meanwhile, and its verdict stalls in the check step until that register frees.
module quadratic_probe_hash_table_top #(
   parameter int SLOTS = qpht_pkg::DEF_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [qpht_pkg::FUNC_W-1:0]   req_func,
   input  logic [qpht_pkg::KEY_W-1:0]    req_key,
   input  logic [qpht_pkg::VAL_W-1:0]    req_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [qpht_pkg::STAT_W-1:0]   rsp_status,
   output logic [qpht_pkg::VAL_W-1:0]    rsp_found_value,
   output logic [qpht_pkg::SLOT_W-1:0]   rsp_slot,
   // table size register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qpht_pkg::SIZE_W-1:0]   csr_wdata
);

   qpht_pkg::cmd_type cmd;
   qpht_pkg::sts_type sts;

   // the user makes size writes only while idle; unenforced here, every transfer is taken at once
   assign csr_ready = 1'b1;

   qpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qpht_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr          (csr_valid && csr_ready),
      .csr_wdata       (csr_wdata),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot        (rsp_slot)
   );

endmodule

>>> tb/sv/tb_quadratic_probe_hash_table_top.sv
// Self-checking testbench for the quadratic-probing hash table top level.
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table_top;

   localparam int SLOTS = qpht_pkg::DEF_SLOTS;
   // Slowest item: capture, divider, then a slot read and a check for each of up to SLOTS probes.
   localparam int SETTLE_CYCLES = 32 + 2 * SLOTS + 10;
   localparam int DRAIN_LIMIT   = 60000;
   localparam int HOLD_CYCLES   = 400;

   // One expected or observed response, in port order.
   typedef struct packed {
      logic [qpht_pkg::STAT_W-1:0] status;
      logic [qpht_pkg::VAL_W-1:0]  found_value;
      logic [qpht_pkg::SLOT_W-1:0] slot;
   } table_answer_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [qpht_pkg::FUNC_W-1:0]   req_func;
   logic [qpht_pkg::KEY_W-1:0]    req_key;
   logic [qpht_pkg::VAL_W-1:0]    req_value;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [qpht_pkg::STAT_W-1:0]   rsp_status;
   logic [qpht_pkg::VAL_W-1:0]    rsp_found_value;
   logic [qpht_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [qpht_pkg::SIZE_W-1:0]   csr_wdata;

   // Shadow copy of the table, the size register and the keys written so far.
   logic [qpht_pkg::SIZE_W-1:0]   shadow_size;
   logic [qpht_pkg::KEY_W-1:0]    shadow_keys   [SLOTS];
   logic [qpht_pkg::VAL_W-1:0]    shadow_values [SLOTS];
   logic                          shadow_occ    [SLOTS];
   logic [qpht_pkg::KEY_W-1:0]    stored_keys   [$];

   table_answer_type   pending_answers [$];
   int unsigned        mismatches = 0;
   int unsigned        idle_pct = 11;
   int unsigned        rsp_hold_request = 0;

   quadratic_probe_hash_table_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot        (rsp_slot),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run, including the clearing pass.
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Walk the probe sequence on the shadow table and update it the way the block must.
   // A size of zero acts as one, anything above the slot count acts as the slot count.
   function automatic table_answer_type probe_table(
         input logic [qpht_pkg::FUNC_W-1:0] func,
         input logic [qpht_pkg::KEY_W-1:0]  key,
         input logic [qpht_pkg::VAL_W-1:0]  value);
      table_answer_type ans;
      int unsigned      n;
      int unsigned      home;
      int unsigned      idx;
      int unsigned      i;
      n = (shadow_size == 0) ? 1 : ((shadow_size > SLOTS) ? SLOTS : shadow_size);
      home = key % n;
      ans.status      = (func == qpht_pkg::FUNC_SEARCH) ? qpht_pkg::STAT_NOT_FOUND
                                                        : qpht_pkg::STAT_FULL;
      ans.found_value = '0;
      ans.slot        = '0;
      for (i = 0; i < n; i++) begin
         idx = (home + (i * i) % n) % n;
         if (!shadow_occ[idx]) begin
            // An empty slot ends both operations; only an insert claims it.
            if (func == qpht_pkg::FUNC_INSERT) begin
               shadow_keys[idx]   = key;
               shadow_values[idx] = value;
               shadow_occ[idx]    = 1'b1;
               ans.status         = qpht_pkg::STAT_INSERTED;
               ans.slot           = idx[qpht_pkg::SLOT_W-1:0];
            end
            break;
         end
         if (func == qpht_pkg::FUNC_SEARCH && shadow_keys[idx] == key) begin
            ans.status      = qpht_pkg::STAT_FOUND;
            ans.found_value = shadow_values[idx];
            ans.slot        = idx[qpht_pkg::SLOT_W-1:0];
            break;
         end
      end
      return ans;
   endfunction

   // Half of the keys already sit in the table, so searches hit and inserts duplicate;
   // the rest are small colliding keys, the key extremes and wide random keys.
   function automatic logic [qpht_pkg::KEY_W-1:0] pick_key();
      logic [31:0] wide;
      wide = $urandom;
      case ($urandom_range(0, 9)) inside
         [0:4]: begin
            if (stored_keys.size() != 0)
               return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            return wide[qpht_pkg::KEY_W-1:0];
         end
         [5:6]: return qpht_pkg::KEY_W'($urandom_range(0, 255));
         7: return $urandom_range(0, 1) ? {qpht_pkg::KEY_W{1'b1}} : '0;
         default: return wide[qpht_pkg::KEY_W-1:0];
      endcase
   endfunction

   // Offer one request, idling at random first, and record its answer once it transfers.
   // Valid stays high after the transfer; the next call or a drain decides what follows.
   task automatic send_request(input logic [qpht_pkg::FUNC_W-1:0] func,
                               input logic [qpht_pkg::KEY_W-1:0]  key,
                               input logic [qpht_pkg::VAL_W-1:0]  value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_answers.push_back(probe_table(func, key, value));
      if (func == qpht_pkg::FUNC_INSERT) begin
         stored_keys.push_back(key);
         if (stored_keys.size() > 256) void'(stored_keys.pop_front());
      end
   endtask

   // Stop offering, wait until every answer is back, then let the block settle.
   task automatic wait_for_answers();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_answers.size() != 0) begin
         $display("%0d responses never arrived", pending_answers.size());
         mismatches += pending_answers.size();
         pending_answers.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the size register; callers drain first so the block is idle.
   task automatic write_table_size(input logic [qpht_pkg::SIZE_W-1:0] size);
      csr_valid <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_size = size;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random_batch(input int unsigned count, input int unsigned insert_pct);
      logic [qpht_pkg::FUNC_W-1:0] func;
      repeat (count) begin
         func = ($urandom_range(0, 99) < insert_pct) ? qpht_pkg::FUNC_INSERT
                                                     : qpht_pkg::FUNC_SEARCH;
         send_request(func, pick_key(), $urandom);
      end
   endtask

   // Reset size of ten: empty-table miss, key extremes, collisions and duplicate inserts.
   task automatic test_default_size();
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(5), '1);
      send_request(qpht_pkg::FUNC_INSERT, '0, '0);
      send_request(qpht_pkg::FUNC_INSERT, {qpht_pkg::KEY_W{1'b1}}, '1);
      send_request(qpht_pkg::FUNC_SEARCH, {qpht_pkg::KEY_W{1'b1}}, '0);
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(10), $urandom);
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(10), 32'h1234_5678);
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(10), 32'h8765_4321);
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(10), '0);
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(20), 32'hA5A5_5A5A);
      send_request(qpht_pkg::FUNC_SEARCH, '0, '1);
      wait_for_answers();
   endtask

   // Size one and zero run out of probes at once; oversized values clamp to the slot count;
   // shrinking afterwards leaves entries beyond the new size out of reach.
   task automatic test_size_extremes();
      write_table_size(qpht_pkg::SIZE_W'(1));
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(3), $urandom);
      send_request(qpht_pkg::FUNC_SEARCH, '0, $urandom);
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(123), $urandom);
      wait_for_answers();
      write_table_size('0);
      send_request(qpht_pkg::FUNC_SEARCH, '0, $urandom);
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(1), $urandom);
      wait_for_answers();
      write_table_size({qpht_pkg::SIZE_W{1'b1}});
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(63), 32'hDEAD_BEEF);
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(63), '0);
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(127), 32'h0BAD_F00D);
      wait_for_answers();
      write_table_size(qpht_pkg::SIZE_W'(SLOTS + 1));
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(127), '0);
      wait_for_answers();
      write_table_size(qpht_pkg::SIZE_W'(5));
      send_request(qpht_pkg::FUNC_SEARCH, {qpht_pkg::KEY_W{1'b1}}, '0);
      send_request(qpht_pkg::FUNC_SEARCH, qpht_pkg::KEY_W'(20), '0);
      send_request(qpht_pkg::FUNC_INSERT, qpht_pkg::KEY_W'(2), $urandom);
      wait_for_answers();
   endtask

   // Sweep sizes up and down so the table fills gradually and full tables get searched.
   task automatic test_random_sizes();
      int unsigned size_plan [] = '{3, 1, 7, 2, 12, 10, 16, 0, 24, 5, 33, 64,
                                    20, 127, 48, 65, 9, 64, 40, 100, 13, 31};
      foreach (size_plan[k]) begin
         write_table_size(qpht_pkg::SIZE_W'(size_plan[k]));
         run_random_batch(60, 40);
         wait_for_answers();
      end
   endtask

   // Drop all idling on both sides for one long stretch.
   task automatic test_unpaced_stretch();
      idle_pct = 0;
      write_table_size(qpht_pkg::SIZE_W'(20));
      run_random_batch(200, 35);
      wait_for_answers();
      idle_pct = 11;
   endtask

   // Hold the response side off while requests keep coming, so the block backs up
   // and stalls its input; then drain completely before moving on.
   task automatic test_output_backpressure();
      write_table_size(qpht_pkg::SIZE_W'(8));
      rsp_hold_request = HOLD_CYCLES;
      run_random_batch(30, 40);
      wait_for_answers();
   endtask

   // Response-side ready: random idling, or a counted hold when one is requested.
   initial begin : rsp_pacing
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Compare every response transfer with the oldest outstanding answer.
   always @(posedge clock) begin : rsp_check
      table_answer_type want;
      table_answer_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{status: rsp_status, found_value: rsp_found_value, slot: rsp_slot};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response status %0d value %h slot %0d",
                        $realtime, got.status, got.found_value, got.slot);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: status %0d/%0d value %h/%h slot %0d/%0d (expected/actual)",
                           $realtime, want.status, got.status, want.found_value,
                           got.found_value, want.slot, got.slot);
            end
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_func    <= qpht_pkg::FUNC_INSERT;
      req_key     <= '0;
      req_value   <= '0;
      csr_valid   <= 1'b0;
      csr_wdata   <= '0;
      shadow_size  = qpht_pkg::SIZE_RESET;
      foreach (shadow_occ[s]) begin
         shadow_occ[s]    = 1'b0;
         shadow_keys[s]   = '0;
         shadow_values[s] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_size();
      test_size_extremes();
      test_random_sizes();
      test_unpaced_stretch();
      test_output_backpressure();
      wait_for_answers();

      if (mismatches == 0 && pending_answers.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
